>>> rtl/nipf_pkg.sv
// Shared constants and types for the noncoherent integration peak detector.
package nipf_pkg;

	localparam int BINS        = 4096;
	localparam int BIN_BITS    = $clog2(BINS);
	localparam int SAMPLE_BITS = 16;
	localparam int SUM_BITS    = 40;
	localparam int TOTAL_BITS  = 52;
	localparam int NOISE_BITS  = TOTAL_BITS - BIN_BITS;
	localparam int MAX_FRAMES  = 256;
	localparam int FRAME_BITS  = 8;
	localparam int CFG_BITS    = 9;
	localparam int ABS_BITS    = SAMPLE_BITS + 1;
	localparam int SQ_BITS     = 2 * ABS_BITS;
	localparam int MAG_BITS    = SQ_BITS + 1;

	typedef struct packed {
		logic [BIN_BITS-1:0] idx;
		logic                first;
		logic                last;
		logic                frame_end;
	} tag_t;

endpackage

>>> rtl/nipf_if.sv
// Sample and report channel interfaces.
interface nipf_sample_if import nipf_pkg::*; ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_i;
	logic signed [SAMPLE_BITS-1:0] sample_q;

	modport source (output valid, output sample_i, output sample_q, input ready);
	modport sink   (input valid, input sample_i, input sample_q, output ready);
endinterface

interface nipf_report_if import nipf_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [BIN_BITS-1:0] peak_bin;
	logic [SUM_BITS-1:0] peak_level;
	logic [SUM_BITS-1:0] noise_level;
	logic                fresh;

	modport source (output valid, output peak_bin, output peak_level, output noise_level,
		output fresh, input ready);
	modport sink   (input valid, input peak_bin, input peak_level, input noise_level,
		input fresh, output ready);
endinterface

>>> rtl/nipf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module nipf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/noncoherent_integrate_peak_find.sv
// Top level of the noncoherent integration peak detector.
// Usage:
//   samples: one I/Q word per bin, bins 0..BINS-1 in order, frame after frame.
//   cfg_we/cfg_wdata: frames_to_integrate, written while the block is idle
//     (0 acts as 1, values above MAX_FRAMES act as MAX_FRAMES).
//   report: one word at the last bin of every frame with the held peak bin,
//     peak level and noise level; fresh is set when that frame closed a run.
// Throughput: one sample word per clock except during a stall (below). The
//   per-bin sums live in one BINS x SUM_BITS RAM, read and written back once
//   per word in a six-stage pipeline: abs, square, magnitude add with RAM
//   read, accumulate with write-back, peak and total update, report.
// Report path: after the last bin of a frame is accepted, its tag passes
//   s1 to s5 and the report word is registered from s5.
// Reset: counters, running peak/total and held values clear to zero,
//   frames_to_integrate returns to 1; the sum RAM is not cleared, the first
//   frame of each run overwrites it.
// Stall: a report word waiting on report.ready does not block input; samples
//   stall only when the next report word is ready to leave and the previous
//   one is still held.
module noncoherent_integrate_peak_find import nipf_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CFG_BITS-1:0] cfg_wdata,
	nipf_sample_if.sink         samples,
	nipf_report_if.source       report
);

	logic [CFG_BITS-1:0]   frames_q;
	logic [BIN_BITS-1:0]   bin_q;
	logic [FRAME_BITS-1:0] frame_q;
	logic [CFG_BITS-1:0]   eff_frames;
	logic                  is_last;
	logic                  adv;
	logic                  acc;
	logic [ABS_BITS-1:0]   abs_i;
	logic [ABS_BITS-1:0]   abs_q;

	logic                  v_s1, v_s2, v_s3, v_s4, v_s5;
	tag_t                  tag_s1, tag_s2, tag_s3, tag_s4, tag_s5;
	logic [ABS_BITS-1:0]   ai_s1, aq_s1;
	logic [SQ_BITS-1:0]    sqi_s2, sqq_s2;
	logic [MAG_BITS-1:0]   mag_s3;
	logic [SUM_BITS-1:0]   val_s4;

	logic [SUM_BITS-1:0]   ram_rdata;
	logic                  ram_we;
	logic                  ram_re;
	logic [SUM_BITS:0]     acc_sum;
	logic [SUM_BITS-1:0]   val;

	logic [TOTAL_BITS-1:0] running_total_q;
	logic [SUM_BITS-1:0]   running_max_q;
	logic [BIN_BITS-1:0]   running_bin_q;
	logic                  clr;
	logic                  upd;
	logic [TOTAL_BITS-1:0] base_total;
	logic [SUM_BITS-1:0]   base_max;
	logic [BIN_BITS-1:0]   base_bin;
	logic [TOTAL_BITS:0]   tot_sum;
	logic [TOTAL_BITS-1:0] rest;

	logic                  res_s5;
	logic                  res_go;
	logic                  report_valid_q;
	logic [BIN_BITS-1:0]   held_bin_q;
	logic [SUM_BITS-1:0]   held_peak_q;
	logic [SUM_BITS-1:0]   held_noise_q;
	logic                  fresh_q;

	// input stage
	always_comb begin
		if (frames_q == '0) begin
			eff_frames = CFG_BITS'(1);
		end else if (frames_q > CFG_BITS'(MAX_FRAMES)) begin
			eff_frames = CFG_BITS'(MAX_FRAMES);
		end else begin
			eff_frames = frames_q;
		end
	end

	assign is_last = ({1'b0, frame_q} + CFG_BITS'(1)) >= eff_frames;
	assign res_s5  = v_s5 && tag_s5.frame_end;
	assign adv     = !(res_s5 && report_valid_q && !report.ready);
	assign acc     = samples.valid && adv;
	assign samples.ready = adv;

	assign abs_i = samples.sample_i[SAMPLE_BITS-1] ?
		(~{1'b1, samples.sample_i} + ABS_BITS'(1)) : {1'b0, samples.sample_i};
	assign abs_q = samples.sample_q[SAMPLE_BITS-1] ?
		(~{1'b1, samples.sample_q} + ABS_BITS'(1)) : {1'b0, samples.sample_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_q <= CFG_BITS'(1);
		end else if (cfg_we) begin
			frames_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_q   <= '0;
			frame_q <= '0;
		end else if (acc) begin
			if (bin_q == BIN_BITS'(BINS - 1)) begin
				bin_q   <= '0;
				frame_q <= is_last ? '0 : frame_q + FRAME_BITS'(1);
			end else begin
				bin_q <= bin_q + BIN_BITS'(1);
			end
		end
	end

	// pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= samples.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s1.idx       <= bin_q;
			tag_s1.first     <= (frame_q == '0);
			tag_s1.last      <= is_last;
			tag_s1.frame_end <= (bin_q == BIN_BITS'(BINS - 1));
			ai_s1            <= abs_i;
			aq_s1            <= abs_q;
			tag_s2           <= tag_s1;
			sqi_s2           <= SQ_BITS'(ai_s1) * SQ_BITS'(ai_s1);
			sqq_s2           <= SQ_BITS'(aq_s1) * SQ_BITS'(aq_s1);
			tag_s3           <= tag_s2;
			mag_s3           <= MAG_BITS'(sqi_s2) + MAG_BITS'(sqq_s2);
			tag_s4           <= tag_s3;
			val_s4           <= val;
			tag_s5           <= tag_s4;
		end
	end

	// sum memory: read in stage 2, accumulate and write back in stage 3
	assign ram_re  = adv && v_s2;
	assign ram_we  = adv && v_s3;
	assign acc_sum = {1'b0, ram_rdata} + (SUM_BITS + 1)'(mag_s3);

	always_comb begin
		if (tag_s3.first) begin
			val = SUM_BITS'(mag_s3);
		end else if (acc_sum[SUM_BITS]) begin
			val = '1;
		end else begin
			val = acc_sum[SUM_BITS-1:0];
		end
	end

	nipf_ram #(
		.WIDTH (SUM_BITS),
		.DEPTH (BINS)
	) u_sums (
		.clk   (clk),
		.we    (ram_we),
		.waddr (tag_s3.idx),
		.wdata (val),
		.re    (ram_re),
		.raddr (tag_s2.idx),
		.rdata (ram_rdata)
	);

	// running peak and total, cleared as the closing frame reports
	assign clr        = res_s5 && tag_s5.last;
	assign upd        = v_s4 && tag_s4.last;
	assign base_total = clr ? '0 : running_total_q;
	assign base_max   = clr ? '0 : running_max_q;
	assign base_bin   = clr ? '0 : running_bin_q;
	assign tot_sum    = {1'b0, base_total} + (TOTAL_BITS + 1)'(val_s4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_total_q <= '0;
			running_max_q   <= '0;
			running_bin_q   <= '0;
		end else if (adv) begin
			if (upd) begin
				running_total_q <= tot_sum[TOTAL_BITS] ? '1 : tot_sum[TOTAL_BITS-1:0];
			end else begin
				running_total_q <= base_total;
			end
			if (upd && (val_s4 > base_max)) begin
				running_max_q <= val_s4;
				running_bin_q <= tag_s4.idx;
			end else begin
				running_max_q <= base_max;
				running_bin_q <= base_bin;
			end
		end
	end

	// report
	assign res_go = res_s5 && adv;
	assign rest   = (running_total_q >= TOTAL_BITS'(running_max_q)) ?
		running_total_q - TOTAL_BITS'(running_max_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			report_valid_q <= 1'b0;
			held_bin_q     <= '0;
			held_peak_q    <= '0;
			held_noise_q   <= '0;
			fresh_q        <= 1'b0;
		end else if (res_go) begin
			report_valid_q <= 1'b1;
			fresh_q        <= tag_s5.last;
			if (tag_s5.last) begin
				held_bin_q   <= running_bin_q;
				held_peak_q  <= running_max_q;
				held_noise_q <= SUM_BITS'(rest[TOTAL_BITS-1 -: NOISE_BITS]);
			end
		end else if (report.ready) begin
			report_valid_q <= 1'b0;
		end
	end

	assign report.valid       = report_valid_q;
	assign report.peak_bin    = held_bin_q;
	assign report.peak_level  = held_peak_q;
	assign report.noise_level = held_noise_q;
	assign report.fresh       = fresh_q;

`ifndef SYNTHESIS
	a_no_ram_collide: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && ram_re) |-> (tag_s3.idx != tag_s2.idx))
		else $error("sum RAM read and write hit the same bin");

	a_peak_in_total: assert property (@(posedge clk) disable iff (!arst_n)
		clr |-> (TOTAL_BITS'(running_max_q) <= running_total_q))
		else $error("running peak exceeds running total at frame close");

	a_stall_only_held: assert property (@(posedge clk) disable iff (!arst_n)
		!samples.ready |-> (report_valid_q && res_s5))
		else $error("input stalled without a pending report word");
`endif

endmodule
